// ----- rtl/core/r2y_pkg.sv -----
// Shared types, constants and helper functions of the RGB to YUV 4:2:0 converter.
// Used by r2y_line_store and rgb_to_yuv420_converter; it depends on nothing else.
`timescale 1ns / 1ps

package r2y_pkg;

    // Configuration port.
    localparam int CFG_W  = 13;
    localparam int IDX_W  = 1;
    localparam int SIZE_W = CFG_W + 1;

    typedef logic [IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t REG_FRAME_WIDTH  = 1'b0;
    localparam cfg_idx_t REG_FRAME_HEIGHT = 1'b1;

    localparam logic [CFG_W-1:0] SIZE_RESET = 13'd4096;

    // Colour conversion, all coefficients scaled by one thousand.
    localparam int NUM_W  = 18;
    localparam int PSUM_W = 9;
    localparam int LINE_W = 2 * PSUM_W;

    typedef logic [NUM_W-1:0]  num_t;
    typedef logic [PSUM_W-1:0] psum_t;
    typedef logic [LINE_W-1:0] line_t;

    localparam num_t Y_R      = 18'd257;
    localparam num_t Y_G      = 18'd504;
    localparam num_t Y_B      = 18'd98;
    localparam num_t Y_OFFSET = 18'd16000;
    localparam num_t U_R      = 18'd148;
    localparam num_t U_G      = 18'd291;
    localparam num_t C_MAIN   = 18'd439;
    localparam num_t V_G      = 18'd368;
    localparam num_t V_B      = 18'd71;
    localparam num_t C_OFFSET = 18'd128000;

    // floor(n / 1000) for any 18-bit n as a multiplication by ceil(2^28 / 1000).
    // The rounding error of the reciprocal stays below one part in 2^28 over that range.
    localparam int          RECIP_SHIFT = 28;
    localparam int          RECIP_W     = 19;
    localparam int          PROD_W      = NUM_W + RECIP_W;
    localparam logic [18:0] RECIP_1000  = 19'd268436;

    function automatic logic [7:0] div_by_1000(input num_t n);
        logic [PROD_W-1:0] prod;
        begin
            prod = PROD_W'(n) * PROD_W'(RECIP_1000);
            return prod[RECIP_SHIFT +: 8];
        end
    endfunction

    // Position flags of one pixel, taken from the counters when it is accepted.
    typedef struct packed {
        logic col_odd;
        logic last_col;
        logic row_odd;
        logic last_row;
        logic frame_end;
    } r2y_ctl_t;

    // Line store access strobes.
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } lsc_t;

endpackage

// ----- rtl/core/r2y_line_store.sv -----
// Line store of the converter: per block column, the U and V pair sums of an even row.
// Depends on r2y_pkg for the access strobe type and the entry width.
`timescale 1ns / 1ps

module r2y_line_store
    import r2y_pkg::*;
#(
    parameter int DEPTH = 2048,
    parameter int AW    = 11
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  lsc_t          ctl,
    input  logic [AW-1:0] rd_addr,
    input  logic [AW-1:0] wr_addr,
    input  line_t         wr_data,
    output line_t         rd_data
);

    line_t mem [DEPTH];
    line_t rd_q_reg;
    line_t fwd_data_reg;
    logic  fwd_hit_reg;
    logic  collide;

    // A read that meets a write to the same entry in the same cycle takes the new data.
    assign collide = ctl.rd_en && ctl.wr_en && (rd_addr == wr_addr);

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_q_reg     <= mem[rd_addr];
            fwd_data_reg <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_hit_reg <= 1'b0;
        end
        else if (ctl.rd_en)
        begin
            fwd_hit_reg <= collide;
        end
    end

    assign rd_data = fwd_hit_reg ? fwd_data_reg : rd_q_reg;

    a_forward: assert property (@(posedge clk) disable iff (!rst_n)
        collide |=> rd_data == $past(wr_data))
        else $error("line store read missed a simultaneous write");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !ctl.rd_en |=> $stable(rd_data))
        else $error("line store read data changed without a read");

    a_write_then_read: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.wr_en ##1 (ctl.rd_en && !ctl.wr_en && rd_addr == $past(wr_addr))
        |=> rd_data == $past(wr_data, 2))
        else $error("line store lost a written entry");

endmodule

// ----- rtl/core/rgb_to_yuv420_converter.sv -----
// Top level of the RGB to YUV 4:2:0 converter: counters, colour arithmetic and output stage.
// Depends on r2y_pkg and instantiates r2y_line_store.
`timescale 1ns / 1ps

// The converter takes one RGB pixel per transaction in raster order, top row first, and
// returns one transaction per pixel carrying its BT.601 luma. On the pixel that closes a
// 2x2 block it also raises chroma_valid and carries the block's averaged U and V; an odd
// last column or last row is handled by counting that column or row twice, and frame_done
// marks the last pixel of the frame. It sustains one pixel per clock while the output is
// taken: each pixel makes one read and at most one write of the line store, which has a
// write port and a read port of its own. The line store holds (MAX_WIDTH + 1) / 2 entries
// and needs no clearing pass after reset, since every entry is written on an even row
// before the odd row below reads it. frame_width and frame_height are taken as 1 when
// written as zero and as the maximum size when larger; they should be changed only
// between frames, with the block empty.

module rgb_to_yuv420_converter
    import r2y_pkg::*;
#(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
)
(
    input  logic             clk,
    input  logic             rst_n,

    input  logic             cfg_write,
    input  cfg_idx_t         cfg_index,
    input  logic [CFG_W-1:0] cfg_data,

    input  logic             in_valid,
    output logic             in_ready,
    input  logic [7:0]       red,
    input  logic [7:0]       green,
    input  logic [7:0]       blue,

    output logic             out_valid,
    input  logic             out_ready,
    output logic [7:0]       luma,
    output logic             chroma_valid,
    output logic [7:0]       chroma_u,
    output logic [7:0]       chroma_v,
    output logic             frame_done
);

    localparam int CW         = $clog2(MAX_WIDTH);
    localparam int RW         = $clog2(MAX_HEIGHT);
    localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;
    localparam int AW         = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

    // Configuration registers.
    logic [CFG_W-1:0] frame_width_reg;
    logic [CFG_W-1:0] frame_height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= SIZE_RESET;
            frame_height_reg <= SIZE_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Effective sizes, held to the range one up to the maximum.
    logic [SIZE_W-1:0] width_eff;
    logic [SIZE_W-1:0] height_eff;

    always_comb
    begin
        if (frame_width_reg == '0)
            width_eff = SIZE_W'(1);
        else if ({1'b0, frame_width_reg} > SIZE_W'(MAX_WIDTH))
            width_eff = SIZE_W'(MAX_WIDTH);
        else
            width_eff = {1'b0, frame_width_reg};

        if (frame_height_reg == '0)
            height_eff = SIZE_W'(1);
        else if ({1'b0, frame_height_reg} > SIZE_W'(MAX_HEIGHT))
            height_eff = SIZE_W'(MAX_HEIGHT);
        else
            height_eff = {1'b0, frame_height_reg};
    end

    // Pipeline occupancy. A stage loads whenever it is empty or its item moves on,
    // so bubbles close up and a waiting result holds off new pixels only when all are full.
    logic v1_reg, v2_reg, v3_reg, v4_reg, out_valid_reg;
    logic take1, take2, take3, take4, take_out;
    logic in_fire;

    assign take_out = !out_valid_reg || out_ready;
    assign take4    = !v4_reg || take_out;
    assign take3    = !v3_reg || take4;
    assign take2    = !v2_reg || take3;
    assign take1    = !v1_reg || take2;
    assign in_ready = take1;
    assign in_fire  = in_valid && take1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take1)    v1_reg        <= in_valid;
            if (take2)    v2_reg        <= v1_reg;
            if (take3)    v3_reg        <= v2_reg;
            if (take4)    v4_reg        <= v3_reg;
            if (take_out) out_valid_reg <= v4_reg;
        end
    end

    // Raster position counters, advanced by each accepted transaction.
    logic [CW-1:0]     col_reg, col_next;
    logic [RW-1:0]     row_reg, row_next;
    logic [SIZE_W-1:0] col_p1;
    logic [SIZE_W-1:0] row_p1;
    r2y_ctl_t          ctl0;
    logic [AW-1:0]     slot0;

    always_comb
    begin
        col_p1         = SIZE_W'(col_reg) + SIZE_W'(1);
        row_p1         = SIZE_W'(row_reg) + SIZE_W'(1);
        ctl0.col_odd   = col_reg[0];
        ctl0.row_odd   = row_reg[0];
        ctl0.last_col  = (col_p1 >= width_eff);
        ctl0.last_row  = (row_p1 >= height_eff);
        ctl0.frame_end = ctl0.last_col && ctl0.last_row;
        slot0          = AW'(col_reg >> 1);

        col_next = col_reg;
        row_next = row_reg;
        if (ctl0.last_col)
        begin
            col_next = '0;
            row_next = ctl0.last_row ? '0 : RW'(row_p1);
        end
        else
        begin
            col_next = CW'(col_p1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (in_fire)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Stage 1: the accepted pixel and its position flags.
    logic [7:0]    r1_reg, g1_reg, b1_reg;
    r2y_ctl_t      ctl1_reg;
    logic [AW-1:0] slot1_reg;

    always_ff @(posedge clk)
    begin
        if (take1)
        begin
            r1_reg    <= red;
            g1_reg    <= green;
            b1_reg    <= blue;
            ctl1_reg  <= ctl0;
            slot1_reg <= slot0;
        end
    end

    // Stage 2: numerators scaled by one thousand. Every one is positive and fits in
    // 18 bits, so the unsigned wrap of the intermediate terms never matters.
    num_t ynum1, unum1, vnum1;

    always_comb
    begin
        ynum1 = num_t'(r1_reg) * Y_R + num_t'(g1_reg) * Y_G + num_t'(b1_reg) * Y_B + Y_OFFSET;
        unum1 = C_OFFSET + num_t'(b1_reg) * C_MAIN - num_t'(r1_reg) * U_R
              - num_t'(g1_reg) * U_G;
        vnum1 = C_OFFSET + num_t'(r1_reg) * C_MAIN - num_t'(g1_reg) * V_G
              - num_t'(b1_reg) * V_B;
    end

    num_t          ynum2_reg, unum2_reg, vnum2_reg;
    r2y_ctl_t      ctl2_reg;
    logic [AW-1:0] slot2_reg;

    always_ff @(posedge clk)
    begin
        if (take2)
        begin
            ynum2_reg <= ynum1;
            unum2_reg <= unum1;
            vnum2_reg <= vnum1;
            ctl2_reg  <= ctl1_reg;
            slot2_reg <= slot1_reg;
        end
    end

    // Stage 3: per-pixel Y, U and V after the division by one thousand.
    logic [7:0]    y3_reg, u3_reg, v3c_reg;
    r2y_ctl_t      ctl3_reg;
    logic [AW-1:0] slot3_reg;

    always_ff @(posedge clk)
    begin
        if (take3)
        begin
            y3_reg    <= div_by_1000(ynum2_reg);
            u3_reg    <= div_by_1000(unum2_reg);
            v3c_reg   <= div_by_1000(vnum2_reg);
            ctl3_reg  <= ctl2_reg;
            slot3_reg <= slot2_reg;
        end
    end

    // Horizontal pairing. An even column that is not the last waits in the pair
    // register; an odd column completes the pair, and a lone last column is doubled.
    logic [15:0] pair_hold_reg, pair_hold_next;
    psum_t       pu3, pv3;
    logic        leave3;

    assign leave3 = v3_reg && take4;

    always_comb
    begin
        if (ctl3_reg.col_odd)
        begin
            pu3 = psum_t'(pair_hold_reg[7:0]) + psum_t'(u3_reg);
            pv3 = psum_t'(pair_hold_reg[15:8]) + psum_t'(v3c_reg);
        end
        else
        begin
            pu3 = {u3_reg, 1'b0};
            pv3 = {v3c_reg, 1'b0};
        end

        pair_hold_next = pair_hold_reg;
        if (!ctl3_reg.col_odd && !ctl3_reg.last_col)
        begin
            pair_hold_next = {v3c_reg, u3_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pair_hold_reg <= '0;
        end
        else if (leave3)
        begin
            pair_hold_reg <= pair_hold_next;
        end
    end

    // Stage 4: the line store entry is read as a pixel enters this stage and
    // written as an even-row pixel that closes a pair, not on the last row, leaves it.
    logic [7:0]    y4_reg;
    psum_t         pu4_reg, pv4_reg;
    r2y_ctl_t      ctl4_reg;
    logic [AW-1:0] slot4_reg;

    always_ff @(posedge clk)
    begin
        if (take4)
        begin
            y4_reg    <= y3_reg;
            pu4_reg   <= pu3;
            pv4_reg   <= pv3;
            ctl4_reg  <= ctl3_reg;
            slot4_reg <= slot3_reg;
        end
    end

    logic        pair_done4;
    logic        block_end4;
    logic        store4;
    lsc_t        ls_ctl;
    line_t       line_rd;
    line_t       line_wr;
    logic [9:0]  bu4, bv4;

    always_comb
    begin
        pair_done4 = ctl4_reg.col_odd || ctl4_reg.last_col;
        block_end4 = pair_done4 && (ctl4_reg.row_odd || ctl4_reg.last_row);
        store4     = pair_done4 && !ctl4_reg.row_odd && !ctl4_reg.last_row;
        line_wr    = {pv4_reg, pu4_reg};

        ls_ctl.rd_en = take4;
        ls_ctl.wr_en = v4_reg && take_out && store4;

        // An odd row adds the stored even-row sums; a lone last row is doubled.
        if (ctl4_reg.row_odd)
        begin
            bu4 = 10'(line_rd[PSUM_W-1:0]) + 10'(pu4_reg);
            bv4 = 10'(line_rd[LINE_W-1:PSUM_W]) + 10'(pv4_reg);
        end
        else
        begin
            bu4 = {pu4_reg, 1'b0};
            bv4 = {pv4_reg, 1'b0};
        end
    end

    r2y_line_store #(
        .DEPTH (LINE_DEPTH),
        .AW    (AW)
    ) u_line_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ls_ctl),
        .rd_addr (slot3_reg),
        .wr_addr (slot4_reg),
        .wr_data (line_wr),
        .rd_data (line_rd)
    );

    // Output register: the block sum divided by four, zero when no block closes.
    logic [7:0] luma_reg, cu_reg, cv_reg;
    logic       cvalid_reg, fdone_reg;

    always_ff @(posedge clk)
    begin
        if (take_out && v4_reg)
        begin
            luma_reg   <= y4_reg;
            cvalid_reg <= block_end4;
            cu_reg     <= block_end4 ? bu4[9:2] : 8'd0;
            cv_reg     <= block_end4 ? bv4[9:2] : 8'd0;
            fdone_reg  <= ctl4_reg.frame_end;
        end
    end

    assign out_valid    = out_valid_reg;
    assign luma         = luma_reg;
    assign chroma_valid = cvalid_reg;
    assign chroma_u     = cu_reg;
    assign chroma_v     = cv_reg;
    assign frame_done   = fdone_reg;

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready))
        else $error("input held off while the output side was free");

    a_frame_closes_block: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && frame_done) |-> chroma_valid)
        else $error("last pixel of the frame did not close a chroma block");

    a_chroma_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !chroma_valid) |-> (chroma_u == 8'd0 && chroma_v == 8'd0))
        else $error("chroma carried a value on a pixel that closes no block");

endmodule

// ----- test/rgb_to_yuv420_converter_tb.sv -----
// Self-checking testbench for rgb_to_yuv420_converter: directed pixel table, then random frames.
// Depends on r2y_pkg and the converter RTL; it needs no other file.
`timescale 1ns / 1ps

module rgb_to_yuv420_converter_tb;

    import r2y_pkg::*;

    localparam int MAX_W         = 4096;
    localparam int MAX_H         = 4096;
    localparam int LINE_SLOTS    = (MAX_W + 1) / 2;
    localparam int PIPE_LATENCY  = 5;
    localparam int QUIET_LIMIT   = 2000;
    localparam int REPORT_LIMIT  = 10;
    localparam int DIRECTED_ROWS = 30;

    // One output transaction of the converter.
    typedef struct packed {
        logic [7:0] luma;
        logic       cv;
        logic [7:0] u;
        logic [7:0] v;
        logic       fd;
    } yuv_t;

    // One row of the directed table: either a register write or a pixel, the latter
    // optionally carrying an expected result typed in by hand.
    typedef struct packed {
        logic             is_reg;
        cfg_idx_t         reg_idx;
        logic [CFG_W-1:0] reg_val;
        logic [7:0]       r;
        logic [7:0]       g;
        logic [7:0]       b;
        logic             typed;
        yuv_t             want;
    } step_t;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_write;
    cfg_idx_t         cfg_index;
    logic [CFG_W-1:0] cfg_data;
    logic             in_valid;
    logic             in_ready;
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic             out_valid;
    logic             out_ready = 1'b0;
    logic [7:0]       luma;
    logic             chroma_valid;
    logic [7:0]       chroma_u;
    logic [7:0]       chroma_v;
    logic             frame_done;

    // Predictor state, kept at the widths of the block.
    logic [CFG_W-1:0] width_reg  = SIZE_RESET;
    logic [CFG_W-1:0] height_reg = SIZE_RESET;
    logic [11:0]      col_pos    = '0;
    logic [11:0]      row_pos    = '0;
    logic [15:0]      pending_pair = '0;
    logic [17:0]      line_sums [0:LINE_SLOTS-1];

    yuv_t        yuv_pending [$];
    step_t       directed_steps [DIRECTED_ROWS];
    int          error_count  = 0;
    int          quiet_cycles = 0;
    int          stall_left   = 0;
    int unsigned pixels_sent  = 0;
    bit          calm_phase   = 1'b0;

    rgb_to_yuv420_converter #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .luma         (luma),
        .chroma_valid (chroma_valid),
        .chroma_u     (chroma_u),
        .chroma_v     (chroma_v),
        .frame_done   (frame_done)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // A register value of zero acts as one, anything above the maximum as the maximum.
    function automatic int unsigned eff_size(input logic [CFG_W-1:0] v, input int maxv);
        if (v == 0)
            return 1;
        if (int'(v) > maxv)
            return maxv;
        return 32'(v);
    endfunction

    // Converts one pixel and advances the raster position, the pair register and the
    // line store exactly as the block should.
    function automatic yuv_t convert_pixel(input logic [7:0] r, input logic [7:0] g,
                                           input logic [7:0] b);
        int unsigned w, h, y, u, v, pu, pv, bu, bv, slot;
        logic        last_col, last_row, pair_done;
        yuv_t        res;
        w         = eff_size(width_reg, MAX_W);
        h         = eff_size(height_reg, MAX_H);
        last_col  = (32'(col_pos) + 1 >= w);
        last_row  = (32'(row_pos) + 1 >= h);
        slot      = 32'(col_pos) >> 1;
        pu        = 0;
        pv        = 0;
        bu        = 0;
        bv        = 0;
        pair_done = 1'b0;
        res       = '0;

        y = (257 * r + 504 * g + 98 * b + 16000) / 1000;
        u = (439 * b + 128000 - 148 * r - 291 * g) / 1000;
        v = (439 * r + 128000 - 368 * g - 71 * b) / 1000;

        // Horizontal pairing: an odd column closes the pair, an odd last column
        // counts its own pixel twice.
        if (col_pos[0])
        begin
            pu        = pending_pair[7:0] + u;
            pv        = pending_pair[15:8] + v;
            pair_done = 1'b1;
        end
        else if (last_col)
        begin
            pu        = 2 * u;
            pv        = 2 * v;
            pair_done = 1'b1;
        end
        else
        begin
            pending_pair = {v[7:0], u[7:0]};
        end

        // Vertical pairing through the line store, with the same doubling on an odd last row.
        if (pair_done)
        begin
            if (row_pos[0])
            begin
                bu     = line_sums[slot][8:0] + pu;
                bv     = line_sums[slot][17:9] + pv;
                res.cv = 1'b1;
            end
            else if (last_row)
            begin
                bu     = 2 * pu;
                bv     = 2 * pv;
                res.cv = 1'b1;
            end
            else
            begin
                line_sums[slot] = {pv[8:0], pu[8:0]};
            end
        end

        res.luma = y[7:0];
        res.fd   = last_col && last_row;
        if (res.cv)
        begin
            res.u = bu[9:2];
            res.v = bv[9:2];
        end

        if (last_col)
        begin
            col_pos = '0;
            row_pos = last_row ? 12'd0 : row_pos + 12'd1;
        end
        else
        begin
            col_pos = col_pos + 12'd1;
        end
        return res;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int idle_length();
        if ($urandom_range(0, 15) == 0)
            return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    // Full-range colour level, biased a little towards the two extremes.
    function automatic logic [7:0] random_level();
        if ($urandom_range(0, 7) == 0)
            return $urandom_range(0, 1) ? 8'hFF : 8'h00;
        return 8'($urandom);
    endfunction

    function automatic step_t pixel_row(input logic [7:0] r, input logic [7:0] g,
                                        input logic [7:0] b);
        step_t s;
        s     = '0;
        s.r   = r;
        s.g   = g;
        s.b   = b;
        return s;
    endfunction

    function automatic step_t checked_row(input logic [7:0] r, input logic [7:0] g,
                                          input logic [7:0] b, input logic [7:0] y,
                                          input logic cv, input logic [7:0] u,
                                          input logic [7:0] v, input logic fd);
        step_t s;
        s       = pixel_row(r, g, b);
        s.typed = 1'b1;
        s.want  = '{luma: y, cv: cv, u: u, v: v, fd: fd};
        return s;
    endfunction

    function automatic step_t reg_row(input cfg_idx_t idx, input logic [CFG_W-1:0] val);
        step_t s;
        s         = '0;
        s.is_reg  = 1'b1;
        s.reg_idx = idx;
        s.reg_val = val;
        return s;
    endfunction

    // Stops offering pixels and waits until every expected result has been taken.
    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (yuv_pending.size() != 0)
            @(posedge clk);
    endtask

    // Register writes happen only with the block empty. The trailing edge keeps two
    // writes in a row from lowering and raising cfg_write in the same time step.
    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] val);
        wait_for_results();
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            REG_FRAME_WIDTH:  width_reg  = val;
            REG_FRAME_HEIGHT: height_reg = val;
            default: ;
        endcase
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    // Offers one pixel transaction after an optional gap and holds it until accepted.
    task automatic push_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                              input logic typed, input yuv_t typed_want);
        int   gap;
        yuv_t predicted;
        gap = 0;
        if (!calm_phase && $urandom_range(0, 2) == 0)
            gap = idle_length();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        red      <= r;
        green    <= g;
        blue     <= b;
        do
            @(posedge clk);
        while (!in_ready);
        predicted = convert_pixel(r, g, b);
        yuv_pending.push_back(typed ? typed_want : predicted);
        pixels_sent++;
    endtask

    // Sets the frame size and streams whole frames of random pixels, so that every odd
    // row reads line store entries written by the even row above it.
    task automatic play_frames(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                               input int frames);
        int unsigned pixels;
        write_reg(REG_FRAME_WIDTH, w);
        write_reg(REG_FRAME_HEIGHT, h);
        pixels = eff_size(w, MAX_W) * eff_size(h, MAX_H) * frames;
        repeat (pixels)
        begin
            push_pixel(random_level(), random_level(), random_level(), 1'b0, '0);
            // Occasionally the source holds back until the block has emptied.
            if ($urandom_range(0, 199) == 0)
                wait_for_results();
        end
    endtask

    // Random frame sizes, mostly small, with zero sizes and odd edges in the mix.
    task automatic run_random_phases(input int unsigned target);
        int unsigned      stop_at;
        logic [CFG_W-1:0] w, h;
        int               frames;
        stop_at = pixels_sent + target;
        while (pixels_sent < stop_at)
        begin
            case ($urandom_range(0, 9))
                0:                w = '0;
                1, 2, 3, 4, 5, 6: w = CFG_W'($urandom_range(1, 8));
                7, 8:             w = CFG_W'($urandom_range(9, 40));
                default:          w = CFG_W'($urandom_range(41, 160));
            endcase
            if (w > 40)
            begin
                h      = CFG_W'($urandom_range(1, 3));
                frames = 1;
            end
            else
            begin
                case ($urandom_range(0, 9))
                    0:       h = '0;
                    9:       h = CFG_W'($urandom_range(9, 24));
                    default: h = CFG_W'($urandom_range(1, 8));
                endcase
                frames = (w > 8) ? 1 : int'($urandom_range(1, 3));
            end
            calm_phase = ($urandom_range(0, 3) == 0);
            play_frames(w, h, frames);
        end
    endtask

    // The sink stalls at random; in a calm phase it starts no new stall.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (stall_left > 0)
            begin
                out_ready  <= 1'b0;
                stall_left <= stall_left - 1;
            end
            else if (!calm_phase && $urandom_range(0, 3) == 0)
            begin
                out_ready  <= 1'b0;
                stall_left <= idle_length() - 1;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // Every accepted result transaction is matched against the oldest expectation.
    always @(posedge clk)
    begin : check_result
        yuv_t want;
        yuv_t got;
        if (rst_n && out_valid && out_ready)
        begin
            got = {luma, chroma_valid, chroma_u, chroma_v, frame_done};
            if (yuv_pending.size() == 0)
            begin
                if (error_count < REPORT_LIMIT)
                    $display("unexpected result: Y=%0d cv=%0d U=%0d V=%0d fd=%0d",
                             got.luma, got.cv, got.u, got.v, got.fd);
                error_count++;
            end
            else
            begin
                want = yuv_pending.pop_front();
                if (got !== want)
                begin
                    if (error_count < REPORT_LIMIT)
                        $display("mismatch: expected Y=%0d cv=%0d U=%0d V=%0d fd=%0d, %s",
                                 want.luma, want.cv, want.u, want.v, want.fd,
                                 $sformatf("got Y=%0d cv=%0d U=%0d V=%0d fd=%0d",
                                           got.luma, got.cv, got.u, got.v, got.fd));
                    error_count++;
                end
            end
        end
    end

    // Watchdog: ends the run when neither channel has moved a transaction for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("watchdog expired with %0d results outstanding", yuv_pending.size());
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n     <= 1'b0;
        cfg_write <= 1'b0;
        cfg_index <= REG_FRAME_WIDTH;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        red       <= '0;
        green     <= '0;
        blue      <= '0;

        // Directed table. Right after reset the frame is 4096 by 4096, so the first pixels
        // carry luma only. Shrinking the frame to one pixel in the middle of the top row
        // closes the frame on the next pixel, using the pair held from the column before.
        // A one-pixel frame returns each pixel's own chroma, for sizes written as one or zero.
        directed_steps = '{
            checked_row(8'd0,   8'd0,   8'd0,   8'd16,  1'b0, 8'd0,   8'd0,   1'b0),
            checked_row(8'd255, 8'd255, 8'd255, 8'd235, 1'b0, 8'd0,   8'd0,   1'b0),
            checked_row(8'd255, 8'd0,   8'd0,   8'd81,  1'b0, 8'd0,   8'd0,   1'b0),
            checked_row(8'd0,   8'd255, 8'd0,   8'd144, 1'b0, 8'd0,   8'd0,   1'b0),
            checked_row(8'd0,   8'd0,   8'd255, 8'd40,  1'b0, 8'd0,   8'd0,   1'b0),
            reg_row(REG_FRAME_WIDTH, 13'd1),
            reg_row(REG_FRAME_HEIGHT, 13'd1),
            checked_row(8'd0,   8'd0,   8'd255, 8'd40,  1'b1, 8'd239, 8'd109, 1'b1),
            checked_row(8'd255, 8'd255, 8'd255, 8'd235, 1'b1, 8'd128, 8'd128, 1'b1),
            checked_row(8'd255, 8'd0,   8'd0,   8'd81,  1'b1, 8'd90,  8'd239, 1'b1),
            reg_row(REG_FRAME_WIDTH, 13'd0),
            reg_row(REG_FRAME_HEIGHT, 13'd0),
            checked_row(8'd0,   8'd255, 8'd0,   8'd144, 1'b1, 8'd53,  8'd34,  1'b1),
            reg_row(REG_FRAME_WIDTH, 13'd2),
            reg_row(REG_FRAME_HEIGHT, 13'd2),
            pixel_row(8'd255, 8'd0,   8'd0),
            pixel_row(8'd0,   8'd255, 8'd0),
            pixel_row(8'd0,   8'd0,   8'd255),
            pixel_row(8'd255, 8'd255, 8'd255),
            reg_row(REG_FRAME_WIDTH, 13'd3),
            reg_row(REG_FRAME_HEIGHT, 13'd3),
            pixel_row(8'd12,  8'd200, 8'd77),
            pixel_row(8'd255, 8'd255, 8'd0),
            pixel_row(8'd0,   8'd255, 8'd255),
            pixel_row(8'd128, 8'd128, 8'd128),
            pixel_row(8'd1,   8'd2,   8'd3),
            pixel_row(8'd254, 8'd253, 8'd252),
            pixel_row(8'd255, 8'd0,   8'd255),
            pixel_row(8'd90,  8'd10,  8'd200),
            pixel_row(8'd37,  8'd150, 8'd240)
        };

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_steps[i])
        begin
            if (directed_steps[i].is_reg)
                write_reg(directed_steps[i].reg_idx, directed_steps[i].reg_val);
            else
                push_pixel(directed_steps[i].r, directed_steps[i].g, directed_steps[i].b,
                           directed_steps[i].typed, directed_steps[i].want);
        end

        run_random_phases(400);

        // Sizes written above the maximum: a few pixels of the top row at the clamped size,
        // then the frame is shrunk to one pixel so that the next pixel closes it.
        calm_phase = 1'b0;
        write_reg(REG_FRAME_WIDTH, 13'd8191);
        write_reg(REG_FRAME_HEIGHT, 13'd8191);
        repeat (6)
            push_pixel(random_level(), random_level(), random_level(), 1'b0, '0);
        write_reg(REG_FRAME_WIDTH, 13'd1);
        write_reg(REG_FRAME_HEIGHT, 13'd1);
        push_pixel(random_level(), random_level(), random_level(), 1'b0, '0);

        run_random_phases(400);

        wait_for_results();
        repeat (3 * PIPE_LATENCY) @(posedge clk);
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ----- rgb_to_yuv420_converter.f -----
rtl/core/r2y_pkg.sv
rtl/core/r2y_line_store.sv
rtl/core/rgb_to_yuv420_converter.sv
test/rgb_to_yuv420_converter_tb.sv
